FILE: rtl/input_latency_tag_monitor_defines.svh
// Assertion helpers for the latency monitor checker.
`ifndef INPUT_LATENCY_TAG_MONITOR_DEFINES_SVH
`define INPUT_LATENCY_TAG_MONITOR_DEFINES_SVH

// Clocked on clk_i, off while rst_ni is low.
`define ILTM_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("iltm checker: assertion failed");

`define ILTM_ASSERT_IMP(lbl, ante, cons) \
  `ILTM_ASSERT(lbl, (ante) |-> (cons))

`endif

FILE: rtl/iltm_pkg.sv
`default_nettype none

package iltm_pkg;

  localparam int unsigned TAG_W = 4;

  localparam logic [1:0] MODE_POLL   = 2'd0;
  localparam logic [1:0] MODE_FETCH  = 2'd1;
  localparam logic [1:0] MODE_ENGINE = 2'd2;
  localparam logic [1:0] MODE_SCAN   = 2'd3;

  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_IGNORED   = 2'd1;
  localparam logic [1:0] STAT_BAD_COLOR = 2'd2;

  localparam logic [15:0] SCALE_RESET = 16'd1618;

  // luma decode: ((y - 15) * 6 / 5) >> 4
  localparam logic [7:0]  Y_BLACK    = 8'd15;
  localparam logic [10:0] Y_GAIN     = 11'd6;
  localparam logic [11:0] DIV5_RECIP = 12'd3277;  // ceil(2^14 / 5), exact for x < 2048

  typedef enum logic [2:0] {
    OP_NONE,
    OP_POLL,
    OP_FETCH,
    OP_ENGINE,
    OP_SCAN
  } op_e;

  typedef struct packed {
    logic [1:0]  mode;
    logic [31:0] now_tick;
    logic [15:0] pad_buttons;
    logic [31:0] scan_color;
    logic        capture_enabled;
  } in_word_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [TAG_W-1:0] tag;
    logic [15:0]      pad_buttons_out;
    logic [7:0]       grey_level;
    logic [31:0]      poll_min_us;
    logic [31:0]      poll_max_us;
    logic [31:0]      poll_total;
    logic [31:0]      fetch_gap_us;
    logic [31:0]      poll_fetch_us;
    logic [31:0]      poll_engine_us;
    logic [31:0]      total_latency_us;
  } out_word_t;

  // classified word from the front queue
  typedef struct packed {
    logic [1:0]       mode;
    logic [31:0]      now_tick;
    logic [15:0]      pad_buttons;
    logic             capture_enabled;
    logic             color_ok;
    logic [TAG_W-1:0] scan_key;
  } cls_t;

  // in flight through the back pipeline; t0/t1 are ticks, then microseconds
  typedef struct packed {
    op_e              op;
    logic [1:0]       status;
    logic [TAG_W-1:0] tag;
    logic [15:0]      pad_out;
    logic [7:0]       grey;
    logic             win_start;
    logic [31:0]      poll_total;
    logic [31:0]      t0;
    logic [31:0]      t1;
  } exe_t;

  function automatic logic [TAG_W-1:0] decode_scan_key(input logic [7:0] luma);
    logic [10:0] scaled;
    logic [22:0] prod;
    scaled = 11'(luma - Y_BLACK) * Y_GAIN;
    prod   = 23'(scaled) * 23'(DIV5_RECIP);
    return prod[21:18];
  endfunction

endpackage

`default_nettype wire

FILE: rtl/iltm_front.sv
`default_nettype none

module iltm_front (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push,
  output logic                    full,
  input  wire iltm_pkg::in_word_t in_word_i,
  output logic                    q_valid_o,
  input  wire logic               q_ready_i,
  output iltm_pkg::cls_t          q_word_o
);

  iltm_pkg::cls_t cls;
  iltm_pkg::cls_t slot_q [2];
  logic           wr_ptr_q, rd_ptr_q;
  logic [1:0]     count_q, count_d;
  logic           do_push, do_pop;
  logic [7:0]     y1, y2;

  assign y1 = in_word_i.scan_color[31:24];
  assign y2 = in_word_i.scan_color[15:8];

  always_comb begin
    cls.mode            = in_word_i.mode;
    cls.now_tick        = in_word_i.now_tick;
    cls.pad_buttons     = in_word_i.pad_buttons;
    cls.capture_enabled = in_word_i.capture_enabled;
    cls.color_ok        = (y1 == y2) && (y1 >= iltm_pkg::Y_BLACK);
    cls.scan_key        = iltm_pkg::decode_scan_key(y1);
  end

  assign full      = (count_q == 2'd2);
  assign q_valid_o = (count_q != 2'd0);
  assign do_push   = push && !full;
  assign do_pop    = q_valid_o && q_ready_i;
  assign q_word_o  = slot_q[rd_ptr_q];

  always_comb begin
    count_d = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 2'd1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (do_pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= cls;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/iltm_back.sv
`default_nettype none

module iltm_back #(
  parameter int unsigned RING_DEPTH    = 16,
  parameter int unsigned MINMAX_WINDOW = 256
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            cfg_we_i,
  input  wire logic [15:0]     cfg_wdata_i,
  input  wire logic            q_valid_i,
  output logic                 q_ready_o,
  input  wire iltm_pkg::cls_t  q_word_i,
  output logic                 empty,
  input  wire logic            pop,
  output iltm_pkg::out_word_t  out_word_o
);

  localparam int unsigned IDX_W = $clog2(RING_DEPTH);
  localparam int unsigned WIN_W = $clog2(MINMAX_WINDOW);
  localparam int unsigned TAG_W = iltm_pkg::TAG_W;
  localparam int unsigned KEYS  = 2 ** TAG_W;

  logic                adv, issue;
  logic [15:0]         scale_q;
  logic                active_q;
  logic [IDX_W-1:0]    ring_idx_q, ring_idx_d;
  logic [31:0]         ring_q [RING_DEPTH];
  logic [31:0]         last_poll_q, last_fetch_q, poll_cnt_q;
  logic [WIN_W-1:0]    win_q, win_d;
  logic [IDX_W-1:0]    slot_lut [KEYS];
  logic [TAG_W-1:0]    rd_key;
  logic [31:0]         rd_stamp;

  iltm_pkg::exe_t      exe, a_q, b_d, b_q;
  logic                a_valid_q, b_valid_q, c_valid_q;
  logic [47:0]         prod0, prod1;

  logic [31:0]         min_q, max_q, gap_q, pf_q, pe_q, tot_q;
  logic [31:0]         min_d, max_d, gap_d, pf_d, pe_d, tot_d;
  iltm_pkg::out_word_t out_d, out_q;

  for (genvar g = 0; g < KEYS; g++) begin : g_slot
    assign slot_lut[g] = IDX_W'(g % RING_DEPTH);
  end

  assign adv       = !c_valid_q || pop;
  assign issue     = q_valid_i && adv;
  assign q_ready_o = adv;
  assign empty     = !c_valid_q;
  assign out_word_o = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q <= iltm_pkg::SCALE_RESET;
    end else if (cfg_we_i) begin
      scale_q <= cfg_wdata_i;
    end
  end

  // stage A: state lookup and update, tick differences
  always_comb begin
    rd_key   = (q_word_i.mode == iltm_pkg::MODE_ENGINE) ?
               q_word_i.pad_buttons[TAG_W-1:0] : q_word_i.scan_key;
    rd_stamp = ring_q[slot_lut[rd_key]];

    exe            = '0;
    exe.op         = iltm_pkg::OP_NONE;
    exe.status     = iltm_pkg::STAT_IGNORED;
    exe.pad_out    = q_word_i.pad_buttons;
    exe.poll_total = poll_cnt_q;
    exe.win_start  = (win_q == '0);

    unique case (q_word_i.mode)
      iltm_pkg::MODE_POLL: begin
        if (active_q) begin
          exe.op         = iltm_pkg::OP_POLL;
          exe.status     = iltm_pkg::STAT_OK;
          exe.t0         = q_word_i.now_tick - last_poll_q;
          exe.poll_total = poll_cnt_q + 32'd1;
        end
      end
      iltm_pkg::MODE_FETCH: begin
        if (q_word_i.capture_enabled) begin
          exe.op      = iltm_pkg::OP_FETCH;
          exe.status  = iltm_pkg::STAT_OK;
          exe.tag     = TAG_W'(ring_idx_q);
          exe.pad_out = {q_word_i.pad_buttons[15:TAG_W], TAG_W'(ring_idx_q)};
          exe.t0      = q_word_i.now_tick - last_fetch_q;
          exe.t1      = q_word_i.now_tick - last_poll_q;
        end
      end
      iltm_pkg::MODE_ENGINE: begin
        if (active_q) begin
          exe.op      = iltm_pkg::OP_ENGINE;
          exe.status  = iltm_pkg::STAT_OK;
          exe.tag     = q_word_i.pad_buttons[TAG_W-1:0];
          exe.pad_out = {q_word_i.pad_buttons[15:TAG_W], {TAG_W{1'b0}}};
          exe.grey    = {q_word_i.pad_buttons[TAG_W-1:0], {TAG_W{1'b0}}};
          exe.t0      = q_word_i.now_tick - rd_stamp;
        end
      end
      iltm_pkg::MODE_SCAN: begin
        if (q_word_i.capture_enabled && active_q) begin
          if (!q_word_i.color_ok) begin
            exe.status = iltm_pkg::STAT_BAD_COLOR;
          end else begin
            exe.op     = iltm_pkg::OP_SCAN;
            exe.status = iltm_pkg::STAT_OK;
            exe.tag    = q_word_i.scan_key;
            exe.t0     = q_word_i.now_tick - rd_stamp;
          end
        end
      end
      default: ;
    endcase
  end

  assign ring_idx_d = (ring_idx_q == IDX_W'(RING_DEPTH - 1)) ? '0 : ring_idx_q + 1'b1;
  assign win_d      = (poll_cnt_q == '1 || win_q == WIN_W'(MINMAX_WINDOW - 1)) ?
                      '0 : win_q + 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q     <= 1'b0;
      ring_idx_q   <= '0;
      last_poll_q  <= '0;
      last_fetch_q <= '0;
      poll_cnt_q   <= '0;
      win_q        <= '0;
      for (int i = 0; i < RING_DEPTH; i++) begin
        ring_q[i] <= '0;
      end
    end else if (issue) begin
      case (exe.op)
        iltm_pkg::OP_POLL: begin
          last_poll_q <= q_word_i.now_tick;
          poll_cnt_q  <= exe.poll_total;
          win_q       <= win_d;
        end
        iltm_pkg::OP_FETCH: begin
          ring_q[ring_idx_q] <= last_poll_q;
          active_q           <= 1'b1;
          ring_idx_q         <= ring_idx_d;
          last_fetch_q       <= q_word_i.now_tick;
        end
        default: ;
      endcase
    end
  end

  // stage B: tick to microsecond scaling
  assign prod0 = 48'(a_q.t0) * 48'(scale_q);
  assign prod1 = 48'(a_q.t1) * 48'(scale_q);

  always_comb begin
    b_d    = a_q;
    b_d.t0 = prod0[47:16];
    b_d.t1 = prod1[47:16];
  end

  // stage C: running metrics and result word
  always_comb begin
    min_d = min_q;
    max_d = max_q;
    gap_d = gap_q;
    pf_d  = pf_q;
    pe_d  = pe_q;
    tot_d = tot_q;
    case (b_q.op)
      iltm_pkg::OP_POLL: begin
        if (b_q.win_start) begin
          min_d = b_q.t0;
          max_d = b_q.t0;
        end else begin
          if (b_q.t0 < min_q) min_d = b_q.t0;
          if (b_q.t0 > max_q) max_d = b_q.t0;
        end
      end
      iltm_pkg::OP_FETCH: begin
        gap_d = b_q.t0;
        pf_d  = b_q.t1;
      end
      iltm_pkg::OP_ENGINE: pe_d  = b_q.t0;
      iltm_pkg::OP_SCAN:   tot_d = b_q.t0;
      default: ;
    endcase

    out_d.status           = b_q.status;
    out_d.tag              = b_q.tag;
    out_d.pad_buttons_out  = b_q.pad_out;
    out_d.grey_level       = b_q.grey;
    out_d.poll_min_us      = min_d;
    out_d.poll_max_us      = max_d;
    out_d.poll_total       = b_q.poll_total;
    out_d.fetch_gap_us     = gap_d;
    out_d.poll_fetch_us    = pf_d;
    out_d.poll_engine_us   = pe_d;
    out_d.total_latency_us = tot_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
      c_valid_q <= 1'b0;
      min_q     <= '0;
      max_q     <= '0;
      gap_q     <= '0;
      pf_q      <= '0;
      pe_q      <= '0;
      tot_q     <= '0;
    end else if (adv) begin
      a_valid_q <= issue;
      b_valid_q <= a_valid_q;
      c_valid_q <= b_valid_q;
      if (b_valid_q) begin
        min_q <= min_d;
        max_q <= max_d;
        gap_q <= gap_d;
        pf_q  <= pf_d;
        pe_q  <= pe_d;
        tot_q <= tot_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      a_q   <= exe;
      b_q   <= b_d;
      out_q <= out_d;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/input_latency_tag_monitor.sv
// Input latency tag monitor.
// Input side is a queue: drive in_word_i and push; the word is taken on a
// clock edge with push high and full low. Result side is a queue too: while
// empty is low the oldest result is on out_word_o, and pop on such an edge
// takes it. Every input word gives exactly one result word, in order.
// A two-word input queue feeds a three-stage back end: state update and
// tick differences, tick-to-microsecond multiply, then running metrics into
// the output register. A pushed word waits in a queue slot and is then
// registered in a_q, b_q and out_q in turn; throughput is one word per cycle
// while pop keeps up. When the receiver stalls, the result holds and the back
// end freezes; the input queue still takes up to two more words before full
// rises. cfg_we_i writes the tick-to-us scale (Q0.16 us per tick) into scale_q;
// write it only while no word is in flight.
// Reset clears the queues, the tag ring, all stamps, counters and metrics,
// and loads the scale with its default; the block is ready right after.
`default_nettype none

module input_latency_tag_monitor #(
  parameter int unsigned RING_DEPTH    = 16,
  parameter int unsigned MINMAX_WINDOW = 256
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [15:0]         cfg_wdata_i,
  input  wire logic                push,
  output logic                     full,
  input  wire iltm_pkg::in_word_t  in_word_i,
  output logic                     empty,
  input  wire logic                pop,
  output iltm_pkg::out_word_t      out_word_o
);

  logic           q_valid, q_ready;
  iltm_pkg::cls_t q_word;

  iltm_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push      (push),
    .full      (full),
    .in_word_i (in_word_i),
    .q_valid_o (q_valid),
    .q_ready_i (q_ready),
    .q_word_o  (q_word)
  );

  iltm_back #(
    .RING_DEPTH    (RING_DEPTH),
    .MINMAX_WINDOW (MINMAX_WINDOW)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .q_valid_i   (q_valid),
    .q_ready_o   (q_ready),
    .q_word_i    (q_word),
    .empty       (empty),
    .pop         (pop),
    .out_word_o  (out_word_o)
  );

endmodule

`default_nettype wire

FILE: rtl/iltm_checker.sv
`default_nettype none
`include "input_latency_tag_monitor_defines.svh"

module iltm_checker (
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                empty,
  input wire logic                pop,
  input wire iltm_pkg::out_word_t out_word_o
);

  `ILTM_ASSERT_IMP(a_result_holds, !empty && !pop, ##1 (!empty && $stable(out_word_o)))
  `ILTM_ASSERT(a_empty_after_reset, $rose(rst_ni) |-> empty)
  `ILTM_ASSERT_IMP(a_grey_matches_tag, !empty && out_word_o.grey_level != 8'd0, out_word_o.status == iltm_pkg::STAT_OK && out_word_o.grey_level[7:4] == out_word_o.tag && out_word_o.grey_level[3:0] == 4'd0)
  `ILTM_ASSERT_IMP(a_unhandled_no_tag, !empty && out_word_o.status != iltm_pkg::STAT_OK, out_word_o.tag == 4'd0 && out_word_o.grey_level == 8'd0)

endmodule

bind input_latency_tag_monitor iltm_checker u_iltm_checker (.*);

`default_nettype wire
